@@ hw/rtl/wfp_pkg.sv @@
// ----------------------------------------------------------------------------
// wfp_pkg
// Shared widths, Q32.32 constants, register indexes and the saturating add
// for the Wang-Frenkel pair force pipeline.
// ----------------------------------------------------------------------------
package wfp_pkg;

  localparam int DIST_W     = 32;
  localparam int RES_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // quotient bits of 2^48 / dist_sq
  localparam int DIV_BITS = 49;

  localparam logic [63:0] Q_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_NEG_ONE = 64'hFFFF_FFFF_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXP_NU       = 3'd0,
    CFG_EXP_MU       = 3'd1,
    CFG_NORM_COEF    = 3'd2,
    CFG_ENERGY_SCALE = 3'd3,
    CFG_CUTOFF_POW   = 3'd4,
    CFG_SIGMA_POW    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic        ovf;
    logic [63:0] val;
  } sadd_t;

  // signed 64-bit add, clamped to the signed range
  function automatic sadd_t sat_add(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    sadd_t       r;
    s     = {x[63], x} + {y[63], y};
    r.ovf = s[64] ^ s[63];
    r.val = r.ovf ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/wfp_in_if.sv @@
// ----------------------------------------------------------------------------
// wfp_in_if
// Input channel: one squared pair distance per item.
// ----------------------------------------------------------------------------
interface wfp_in_if import wfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] dist_sq;

  modport source (output valid, output dist_sq, input ready);
  modport sink   (input valid, input dist_sq, output ready);
endinterface

@@ hw/rtl/wfp_out_if.sv @@
// ----------------------------------------------------------------------------
// wfp_out_if
// Result channel: force factor, pair energy and saturation flag.
// ----------------------------------------------------------------------------
interface wfp_out_if import wfp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] force_factor;
  logic signed [RES_W-1:0] pair_energy;
  logic                    saturated;

  modport source (output valid, output force_factor, output pair_energy,
                  output saturated, input ready);
  modport sink   (input valid, input force_factor, input pair_energy,
                  input saturated, output ready);
endinterface

@@ hw/rtl/wfp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// wfp_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wfp_cfg_if import wfp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/wfp_qmul.sv @@
// ----------------------------------------------------------------------------
// wfp_qmul
// Pipelined signed Q32.32 multiplier, LANES products in parallel, four
// stages: magnitude, 32x32 partial products, partial sums, round/saturate.
// With act_i low a lane passes its a operand unchanged and raises no flag.
// ----------------------------------------------------------------------------
module wfp_qmul import wfp_pkg::*; #(
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic                   act_i,
  input  logic [LANES-1:0][63:0] a_i,
  input  logic [LANES-1:0][63:0] b_i,
  input  logic [SW-1:0]          side_i,
  output logic                   valid_o,
  output logic [LANES-1:0][63:0] prod_o,
  output logic                   flag_o,
  output logic [SW-1:0]          side_o
);

  // stage 1
  logic                   v1_q, act1_q;
  logic [SW-1:0]          side1_q;
  logic [LANES-1:0]       neg1_q;
  logic [LANES-1:0][63:0] ux1_q, uy1_q, a1_q;
  // stage 2
  logic                   v2_q, act2_q;
  logic [SW-1:0]          side2_q;
  logic [LANES-1:0]       neg2_q;
  logic [LANES-1:0][63:0] a2_q, p00_q, p01_q, p10_q, p11_q;
  // stage 3
  logic                   v3_q, act3_q;
  logic [SW-1:0]          side3_q;
  logic [LANES-1:0]       neg3_q, cy3_q;
  logic [LANES-1:0][1:0]  mh3_q;
  logic [LANES-1:0][31:0] lh3_q;
  logic [LANES-1:0][63:0] a3_q, hi03_q;
  // stage 4 (output)
  logic                   v4_q, flag4_q;
  logic [SW-1:0]          side4_q;
  logic [LANES-1:0][63:0] prod4_q;

  logic [LANES-1:0]       neg_d;
  logic [LANES-1:0][63:0] ux_d, uy_d;
  logic [LANES-1:0][1:0]  mh_d;
  logic [LANES-1:0]       cy_d;
  logic [LANES-1:0][31:0] lh_d;
  logic [LANES-1:0][63:0] hi0_d;
  logic [LANES-1:0][63:0] res_d;
  logic                   flag_d;

  always_comb begin
    logic [33:0] mid;
    logic [64:0] r65;
    logic [63:0] hi, m, lim;
    logic        ovf;
    flag_d = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      neg_d[l] = a_i[l][63] ^ b_i[l][63];
      ux_d[l]  = a_i[l][63] ? 64'd0 - a_i[l] : a_i[l];
      uy_d[l]  = b_i[l][63] ? 64'd0 - b_i[l] : b_i[l];

      mid      = 34'(p00_q[l][63:32]) + 34'(p01_q[l][31:0]) + 34'(p10_q[l][31:0]);
      r65      = {1'b0, mid[31:0], p00_q[l][31:0]} + 65'h0_8000_0000;
      mh_d[l]  = mid[33:32];
      cy_d[l]  = r65[64];
      lh_d[l]  = r65[63:32];
      hi0_d[l] = p11_q[l] + 64'(p01_q[l][63:32]) + 64'(p10_q[l][63:32]);

      hi  = hi03_q[l] + 64'(mh3_q[l]) + 64'(cy3_q[l]);
      m   = {hi[31:0], lh3_q[l]};
      lim = neg3_q[l] ? Q_MIN : Q_MAX;
      ovf = (hi[63:32] != 32'd0) || (m > lim);
      if (!act3_q) begin
        res_d[l] = a3_q[l];
      end else if (ovf) begin
        res_d[l] = neg3_q[l] ? Q_MIN : Q_MAX;
      end else begin
        res_d[l] = neg3_q[l] ? 64'd0 - m : m;
      end
      flag_d = flag_d | (act3_q & ovf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act1_q  <= act_i;
      side1_q <= side_i;
      neg1_q  <= neg_d;
      ux1_q   <= ux_d;
      uy1_q   <= uy_d;
      a1_q    <= a_i;

      act2_q  <= act1_q;
      side2_q <= side1_q;
      neg2_q  <= neg1_q;
      a2_q    <= a1_q;
      for (int l = 0; l < LANES; l++) begin
        p00_q[l] <= {32'd0, ux1_q[l][31:0]}  * {32'd0, uy1_q[l][31:0]};
        p01_q[l] <= {32'd0, ux1_q[l][31:0]}  * {32'd0, uy1_q[l][63:32]};
        p10_q[l] <= {32'd0, ux1_q[l][63:32]} * {32'd0, uy1_q[l][31:0]};
        p11_q[l] <= {32'd0, ux1_q[l][63:32]} * {32'd0, uy1_q[l][63:32]};
      end

      act3_q  <= act2_q;
      side3_q <= side2_q;
      neg3_q  <= neg2_q;
      a3_q    <= a2_q;
      mh3_q   <= mh_d;
      cy3_q   <= cy_d;
      lh3_q   <= lh_d;
      hi03_q  <= hi0_d;

      side4_q <= side3_q;
      prod4_q <= res_d;
      flag4_q <= flag_d;
    end
  end

  assign valid_o = v4_q;
  assign prod_o  = prod4_q;
  assign flag_o  = flag4_q;
  assign side_o  = side4_q;

endmodule

@@ hw/rtl/wang_frenkel_pair_force_top.sv @@
// ----------------------------------------------------------------------------
// wang_frenkel_pair_force_top
// Wang-Frenkel pair force factor and energy from one squared distance,
// fully pipelined, signed Q32.32 arithmetic with saturation.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  in_ch    in   valid/ready     dist_sq[31:0]
//  out_ch   out  valid/ready     force_factor[63:0], pair_energy[63:0], saturated
//  cfg_ch   in   valid/ready     index[2:0], data[31:0]  (ready tied high)
//
// One item per cycle unless the output stalls. The pipe is a 49-step
// restoring divider (one quotient bit per stage), then chains of 4-stage
// Q32.32 multipliers for the powers and the products, plus add stages.
// All stages advance together whenever the output register is empty or
// being taken; a stall freezes the pipe, so no item is lost or repeated.
// Reset loads the register defaults and clears all valid bits.
module wang_frenkel_pair_force_top import wfp_pkg::*; #(
  parameter int MAX_EXPONENT = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wfp_in_if.sink    in_ch,
  wfp_out_if.source out_ch,
  wfp_cfg_if.sink   cfg_ch
);

  localparam int EW = $clog2(MAX_EXPONENT + 1);
  localparam int NP = MAX_EXPONENT - 1;
  localparam int NB = 2 * MAX_EXPONENT - 2;

  typedef struct packed {
    logic        zero;
    logic        flag;
    logic [63:0] r2inv;
    logic [63:0] p;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] bodd;
    logic [63:0] beven;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] pr;
    logic [63:0] ea;
    logic [63:0] en;
    logic [63:0] s;
    logic [63:0] fs;
    logic [63:0] frc;
  } item_t;

  localparam int SW = $bits(item_t);

  // --------------------------------------------------------------------------
  // registers
  logic [3:0]  exp_nu_q, exp_mu_q;
  logic [31:0] norm_q, escale_q, cut_q, sig_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_nu_q <= 4'd1;
      exp_mu_q <= 4'd1;
      norm_q   <= 32'd65536;
      escale_q <= 32'd65536;
      cut_q    <= 32'd262144;
      sig_q    <= 32'd65536;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_EXP_NU:       exp_nu_q <= cfg_ch.data[3:0];
        CFG_EXP_MU:       exp_mu_q <= cfg_ch.data[3:0];
        CFG_NORM_COEF:    norm_q   <= cfg_ch.data;
        CFG_ENERGY_SCALE: escale_q <= cfg_ch.data;
        CFG_CUTOFF_POW:   cut_q    <= cfg_ch.data;
        CFG_SIGMA_POW:    sig_q    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic [EW-1:0] nu_eff, mu_eff;
  logic [EW:0]   mu2, nu2m1;
  logic [63:0]   nm64, e064, rc64, sg64, k1, t2a;

  // zero acts as one, large values clamp to the maximum
  assign nu_eff = (exp_nu_q == 4'd0) ? EW'(1) :
                  (32'(exp_nu_q) > 32'(MAX_EXPONENT)) ? EW'(MAX_EXPONENT) : EW'(exp_nu_q);
  assign mu_eff = (exp_mu_q == 4'd0) ? EW'(1) :
                  (32'(exp_mu_q) > 32'(MAX_EXPONENT)) ? EW'(MAX_EXPONENT) : EW'(exp_mu_q);
  assign mu2    = {mu_eff, 1'b0};
  assign nu2m1  = {nu_eff, 1'b0} - (EW+1)'(1);

  assign nm64 = {16'd0, norm_q, 16'd0};
  assign e064 = {16'd0, escale_q, 16'd0};
  assign rc64 = {16'd0, cut_q, 16'd0};
  assign sg64 = {16'd0, sig_q, 16'd0};
  // exact integer scalings, never overflow
  assign k1   = sg64 * {{(63-EW){1'b0}}, mu2};
  assign t2a  = {14'd0, norm_q, 18'd0};

  // --------------------------------------------------------------------------
  // pipeline advance
  logic out_v_q;
  logic en;

  assign en          = !out_v_q || out_ch.ready;
  assign in_ch.ready = en;

  // --------------------------------------------------------------------------
  // reciprocal: restoring division of 2^48 + dist/2 by dist
  logic [DIV_BITS:0]  dv_q;
  logic [DIV_BITS:0]  dzero_q;
  logic [48:0]        dnum_q [DIV_BITS+1];
  logic [31:0]        drem_q [DIV_BITS+1];
  logic [31:0]        dden_q [DIV_BITS+1];
  logic [48:0]        dnum_d [DIV_BITS];
  logic [31:0]        drem_d [DIV_BITS];

  always_comb begin
    logic [32:0] t;
    logic        ge;
    for (int k = 0; k < DIV_BITS; k++) begin
      t         = {drem_q[k], dnum_q[k][48]};
      ge        = t >= {1'b0, dden_q[k]};
      drem_d[k] = ge ? 32'(t - {1'b0, dden_q[k]}) : t[31:0];
      dnum_d[k] = {dnum_q[k][47:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en) begin
      dv_q <= {dv_q[DIV_BITS-1:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dnum_q[0]  <= {1'b1, 48'd0} + 49'(in_ch.dist_sq[31:1]);
      drem_q[0]  <= 32'd0;
      dden_q[0]  <= in_ch.dist_sq;
      dzero_q[0] <= (in_ch.dist_sq == 32'd0);
      for (int k = 0; k < DIV_BITS; k++) begin
        dnum_q[k+1]  <= dnum_d[k];
        drem_q[k+1]  <= drem_d[k];
        dden_q[k+1]  <= dden_q[k];
        dzero_q[k+1] <= dzero_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // p = r2inv^mu
  item_t     pc_it [NP+1];
  logic [NP:0] pc_v;

  always_comb begin
    pc_it[0]       = '0;
    pc_it[0].zero  = dzero_q[DIV_BITS];
    pc_it[0].r2inv = 64'(dnum_q[DIV_BITS]);
    pc_it[0].p     = 64'(dnum_q[DIV_BITS]);
  end
  assign pc_v[0] = dv_q[DIV_BITS];

  for (genvar i = 1; i <= NP; i++) begin : g_pow_p
    logic [SW-1:0] so;
    logic [63:0]   pr;
    logic          fl;
    wfp_qmul #(.LANES(1), .SW(SW)) u_mul (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(pc_v[i-1]),
      .act_i  (32'(mu_eff) > 32'(i)),
      .a_i    (pc_it[i-1].p),
      .b_i    (pc_it[i-1].r2inv),
      .side_i (pc_it[i-1]),
      .valid_o(pc_v[i]),
      .prod_o (pr),
      .flag_o (fl),
      .side_o (so)
    );
    always_comb begin
      pc_it[i]      = item_t'(so);
      pc_it[i].p    = pr;
      pc_it[i].flag = pc_it[i].flag | fl;
    end
  end

  // --------------------------------------------------------------------------
  // sigma_pow*p and cutoff_pow*p, then subtract one
  logic [SW-1:0]      g0_so;
  logic [1:0][63:0]   g0_pr;
  logic               g0_v, g0_f;

  wfp_qmul #(.LANES(2), .SW(SW)) u_g0 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(pc_v[NP]),
    .act_i  (1'b1),
    .a_i    ({sg64, rc64}),
    .b_i    ({pc_it[NP].p, pc_it[NP].p}),
    .side_i (pc_it[NP]),
    .valid_o(g0_v),
    .prod_o (g0_pr),
    .flag_o (g0_f),
    .side_o (g0_so)
  );

  item_t ad1_q, ad1_d;
  logic  ad1_v_q;

  always_comb begin
    sadd_t sa, sb;
    sa         = sat_add(g0_pr[1], Q_NEG_ONE);
    sb         = sat_add(g0_pr[0], Q_NEG_ONE);
    ad1_d      = item_t'(g0_so);
    ad1_d.a    = sa.val;
    ad1_d.b    = sb.val;
    ad1_d.bodd = sb.val;
    ad1_d.flag = ad1_d.flag | g0_f | sa.ovf | sb.ovf;
  end

  // --------------------------------------------------------------------------
  // bodd = b^(2nu-1)
  item_t       bc_it [NB+1];
  logic [NB:0] bc_v;

  assign bc_it[0] = ad1_q;
  assign bc_v[0]  = ad1_v_q;

  for (genvar i = 1; i <= NB; i++) begin : g_pow_b
    logic [SW-1:0] so;
    logic [63:0]   pr;
    logic          fl;
    wfp_qmul #(.LANES(1), .SW(SW)) u_mul (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(bc_v[i-1]),
      .act_i  (32'(nu2m1) > 32'(i)),
      .a_i    (bc_it[i-1].bodd),
      .b_i    (bc_it[i-1].b),
      .side_i (bc_it[i-1]),
      .valid_o(bc_v[i]),
      .prod_o (pr),
      .flag_o (fl),
      .side_o (so)
    );
    always_comb begin
      bc_it[i]      = item_t'(so);
      bc_it[i].bodd = pr;
      bc_it[i].flag = bc_it[i].flag | fl;
    end
  end

  // --------------------------------------------------------------------------
  // beven, 4nm*rc, p*r2inv, e0*a
  logic [SW-1:0]    ga_so;
  logic [3:0][63:0] ga_pr;
  logic             ga_v, ga_f;
  item_t            ga_it;

  wfp_qmul #(.LANES(4), .SW(SW)) u_ga (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(bc_v[NB]),
    .act_i  (1'b1),
    .a_i    ({bc_it[NB].bodd, t2a, bc_it[NB].p, e064}),
    .b_i    ({bc_it[NB].b, rc64, bc_it[NB].r2inv, bc_it[NB].a}),
    .side_i (bc_it[NB]),
    .valid_o(ga_v),
    .prod_o (ga_pr),
    .flag_o (ga_f),
    .side_o (ga_so)
  );

  always_comb begin
    ga_it       = item_t'(ga_so);
    ga_it.beven = ga_pr[3];
    ga_it.t2    = ga_pr[2];
    ga_it.pr    = ga_pr[1];
    ga_it.ea    = ga_pr[0];
    ga_it.flag  = ga_it.flag | ga_f;
  end

  // t1 = 2mu*sg*beven, t2 *= a, energy = e0*a*beven
  logic [SW-1:0]    gb_so;
  logic [2:0][63:0] gb_pr;
  logic             gb_v, gb_f;
  item_t            gb_it;

  wfp_qmul #(.LANES(3), .SW(SW)) u_gb (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(ga_v),
    .act_i  (1'b1),
    .a_i    ({k1, ga_it.t2, ga_it.ea}),
    .b_i    ({ga_it.beven, ga_it.a, ga_it.beven}),
    .side_i (ga_it),
    .valid_o(gb_v),
    .prod_o (gb_pr),
    .flag_o (gb_f),
    .side_o (gb_so)
  );

  always_comb begin
    gb_it      = item_t'(gb_so);
    gb_it.t1   = gb_pr[2];
    gb_it.t2   = gb_pr[1];
    gb_it.en   = gb_pr[0];
    gb_it.flag = gb_it.flag | gb_f;
  end

  // t2 *= bodd
  logic [SW-1:0] gc_so;
  logic [63:0]   gc_pr;
  logic          gc_v, gc_f;

  wfp_qmul #(.LANES(1), .SW(SW)) u_gc (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(gb_v),
    .act_i  (1'b1),
    .a_i    (gb_it.t2),
    .b_i    (gb_it.bodd),
    .side_i (gb_it),
    .valid_o(gc_v),
    .prod_o (gc_pr),
    .flag_o (gc_f),
    .side_o (gc_so)
  );

  item_t ad2_q, ad2_d;
  logic  ad2_v_q;

  always_comb begin
    sadd_t ss;
    ad2_d      = item_t'(gc_so);
    ss         = sat_add(ad2_d.t1, gc_pr);
    ad2_d.t2   = gc_pr;
    ad2_d.s    = ss.val;
    ad2_d.flag = ad2_d.flag | gc_f | ss.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ad1_v_q <= 1'b0;
      ad2_v_q <= 1'b0;
    end else if (en) begin
      ad1_v_q <= g0_v;
      ad2_v_q <= gc_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ad1_q <= ad1_d;
      ad2_q <= ad2_d;
    end
  end

  // fs = e0*(t1+t2)
  logic [SW-1:0] gd_so;
  logic [63:0]   gd_pr;
  logic          gd_v, gd_f;
  item_t         gd_it;

  wfp_qmul #(.LANES(1), .SW(SW)) u_gd (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(ad2_v_q),
    .act_i  (1'b1),
    .a_i    (e064),
    .b_i    (ad2_q.s),
    .side_i (ad2_q),
    .valid_o(gd_v),
    .prod_o (gd_pr),
    .flag_o (gd_f),
    .side_o (gd_so)
  );

  always_comb begin
    gd_it      = item_t'(gd_so);
    gd_it.fs   = gd_pr;
    gd_it.flag = gd_it.flag | gd_f;
  end

  // force = fs * (p*r2inv)
  logic [SW-1:0] ge_so;
  logic [63:0]   ge_pr;
  logic          ge_v, ge_f;
  item_t         ge_it;

  wfp_qmul #(.LANES(1), .SW(SW)) u_ge (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(gd_v),
    .act_i  (1'b1),
    .a_i    (gd_it.fs),
    .b_i    (gd_it.pr),
    .side_i (gd_it),
    .valid_o(ge_v),
    .prod_o (ge_pr),
    .flag_o (ge_f),
    .side_o (ge_so)
  );

  always_comb begin
    ge_it      = item_t'(ge_so);
    ge_it.frc  = ge_pr;
    ge_it.flag = ge_it.flag | ge_f;
  end

  // --------------------------------------------------------------------------
  // output register; zero distance overrides everything
  logic [63:0] out_frc_q, out_en_q;
  logic        out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= ge_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_frc_q <= ge_it.zero ? Q_MAX : ge_it.frc;
      out_en_q  <= ge_it.zero ? Q_MAX : ge_it.en;
      out_sat_q <= ge_it.zero | ge_it.flag;
    end
  end

  assign out_ch.valid        = out_v_q;
  assign out_ch.force_factor = out_frc_q;
  assign out_ch.pair_energy  = out_en_q;
  assign out_ch.saturated    = out_sat_q;

  // --------------------------------------------------------------------------
  // assertions
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[DIV_BITS] && !dzero_q[DIV_BITS] |-> drem_q[DIV_BITS] < dden_q[DIV_BITS])
    else $error("divider remainder not below divisor");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_q))
    else $error("divider valid bits moved during stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> dv_q[0])
    else $error("accepted item missing from first stage");

endmodule
